@@ hw/rtl/rk4dap_pkg.sv @@
// Shared types and fixed constants for the RK4 drag apogee predictor.
// Depends on nothing; used by every module in hw/rtl.
`timescale 1ns / 1ps

package rk4dap_pkg;

    // request and result payloads
    typedef struct packed {
        logic signed [31:0] velocity;
        logic signed [31:0] height;
        logic        [15:0] brake_area;
    } t_req;

    typedef struct packed {
        logic signed [31:0] apogee;
        logic        [10:0] steps_taken;
        logic               hit_limit;
    } t_res;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAG_COEFF = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE  = 2'd1;
    localparam logic [15:0] CD_RESET   = 16'd6554;
    localparam logic [15:0] STEP_RESET = 16'd6554;

    // rho / (2 m) in Q0.16
    localparam logic [13:0] K_DRAG = 14'd8474;

    // serial multiplier: multiplier operand width and bit counts per use
    localparam int MB_W  = 32;
    localparam int LEN_W = 6;
    localparam logic [LEN_W-1:0] LEN_MAG  = 6'd32;
    localparam logic [LEN_W-1:0] LEN_C    = 6'd30;
    localparam logic [LEN_W-1:0] LEN_Q16  = 6'd16;
    localparam logic [LEN_W-1:0] LEN_KDRG = 6'd14;

    typedef struct packed {
        logic             start;
        logic [LEN_W-1:0] len;
    } t_mul_ctl;

    // weighted derivative sum and the divide-by-six operand
    localparam int KSW = 35;
    localparam int DVW = 36;

endpackage

@@ hw/rtl/rk4dap_smul.sv @@
// Shift-add multiplier: signed multiplicand times unsigned multiplier, one bit a cycle.
// Depends on rk4dap_pkg.
`timescale 1ns / 1ps

module rk4dap_smul #(
    parameter int AW = 49
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  rk4dap_pkg::t_mul_ctl                i_ctl,
    input  logic signed [AW-1:0]                i_a,
    input  logic [rk4dap_pkg::MB_W-1:0]         i_b,
    output logic                                o_done,
    output logic signed [AW+rk4dap_pkg::MB_W-1:0] o_prod
);
    import rk4dap_pkg::*;

    localparam int PW = AW + MB_W;

    logic signed [PW-1:0] r_acc;
    logic signed [PW-1:0] r_a;
    logic [MB_W-1:0]      r_b;
    logic [LEN_W-1:0]     r_cnt;
    logic                 r_busy;
    logic                 r_done;

    // one multiplier bit per cycle, LSB first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_acc  <= '0;
                r_a    <= PW'(i_a);
                r_b    <= i_b;
                r_cnt  <= i_ctl.len;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_b[0]) begin
                    r_acc <= r_acc + r_a;
                end
                r_a   <= r_a <<< 1;
                r_b   <= r_b >> 1;
                r_cnt <= r_cnt - LEN_W'(1);
                if (r_cnt == LEN_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

@@ hw/rtl/rk4dap_div6.sv @@
// Restoring divider by the constant six, floor rounding, one quotient bit a cycle.
// Depends on rk4dap_pkg.
`timescale 1ns / 1ps

module rk4dap_div6 #(
    parameter int W = 36
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [W-1:0] i_x,
    output logic                o_done,
    output logic signed [W-1:0] o_q
);
    import rk4dap_pkg::*;

    localparam int CNW = $clog2(W + 1);

    logic [W-1:0]   r_num;
    logic [2:0]     r_rem;
    logic [CNW-1:0] r_cnt;
    logic           r_neg;
    logic           r_busy;
    logic           r_done;

    logic [W-1:0] n_u;
    logic [3:0]   n_trial;
    logic [3:0]   n_sub;
    logic         n_qbit;

    // floor(x/6) for negative x is -((5 - x) / 6); 5 - x = ~x + 6
    assign n_u     = i_x[W-1] ? (~i_x + W'(6)) : i_x;
    assign n_trial = {r_rem, r_num[W-1]};
    assign n_sub   = n_trial - 4'd6;
    assign n_qbit  = (n_trial >= 4'd6);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_num  <= n_u;
                r_rem  <= 3'd0;
                r_neg  <= i_x[W-1];
                r_cnt  <= CNW'(W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= n_qbit ? n_sub[2:0] : n_trial[2:0];
                r_num <= {r_num[W-2:0], n_qbit};
                r_cnt <= r_cnt - CNW'(1);
                if (r_cnt == CNW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_neg ? -signed'(r_num) : signed'(r_num);

endmodule

@@ hw/rtl/rk4_drag_apogee_predictor_core.sv @@
// RK4 drag apogee predictor, top level: sequencer, state registers and output stage.
// Depends on rk4dap_pkg, rk4dap_smul and rk4dap_div6.
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low; busy stays high until the
// result has been formed, and the result then appears for one cycle with o_done high.
// The receiver cannot stall, so sample o_result whenever o_done is high. Latency is
// set by the shift-add multiplier and the divide-by-six unit, both one bit a cycle.
// Each RK4 step costs four derivative evaluations (32 + 30 bit products), three stage
// updates and one final update (16 bit products) and a division by six.
// Configuration may be written only while busy is low.

module rk4_drag_apogee_predictor_core #(
    parameter int MAX_STEPS = 1024,
    parameter int FRAC_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  rk4dap_pkg::t_req                 i_request,
    output logic                             o_done,
    output rk4dap_pkg::t_res                 o_result,
    input  logic                             i_cfg_we,
    input  logic [rk4dap_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [15:0]                      i_cfg_data
);
    import rk4dap_pkg::*;

    localparam int V2W  = 64 - FRAC_BITS;
    localparam int SUMW = 31 + $clog2(MAX_STEPS);
    localparam int AW   = ((V2W > SUMW) ? V2W : SUMW) + 1;
    localparam int PW   = AW + MB_W;
    localparam int XW   = PW + 2;
    localparam int CW   = $clog2(MAX_STEPS + 1);
    localparam longint G_FIX = ((longint'(981) << FRAC_BITS) + 50) / 100;
    localparam logic signed [AW+1:0] G_W = (AW+2)'(G_FIX);
    localparam logic signed [XW-1:0] X_MAX = XW'(64'sd2147483647);
    localparam logic signed [XW-1:0] X_MIN = XW'(-64'sd2147483648);
    localparam logic [CW-1:0] MAX_C = CW'(MAX_STEPS);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_C1   = 9'b000000010,
        S_C2   = 9'b000000100,
        S_SQ   = 9'b000001000,
        S_DR   = 9'b000010000,
        S_ST   = 9'b000100000,
        S_AC   = 9'b001000000,
        S_DV   = 9'b010000000,
        S_AP   = 9'b100000000
    } t_state;

    function automatic logic signed [31:0] f_sat32(input logic signed [XW-1:0] x);
        logic signed [31:0] r;
        if (x > X_MAX) begin
            r = 32'sh7FFFFFFF;
        end else if (x < X_MIN) begin
            r = 32'sh80000000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] f_mag(input logic signed [31:0] x);
        return x[31] ? (~x + 32'd1) : x;
    endfunction

    t_state               r_state;
    logic [15:0]          r_cd;
    logic [15:0]          r_step;
    logic signed [31:0]   r_v;
    logic signed [31:0]   r_h;
    logic [29:0]          r_c;
    logic [1:0]           r_stage;
    logic signed [KSW-1:0] r_ksum;
    logic [SUMW-1:0]      r_sum;
    logic [CW-1:0]        r_count;
    logic                 r_limit;
    t_mul_ctl             r_mctl;
    logic signed [AW-1:0] r_ma;
    logic [MB_W-1:0]      r_mb;
    logic                 r_dgo;
    logic signed [DVW-1:0] r_dx;
    logic                 r_done;
    t_res                 r_res;

    logic                  w_mdone;
    logic signed [PW-1:0]  w_prod;
    logic                  w_ddone;
    logic signed [DVW-1:0] w_q;

    logic signed [AW+1:0]  w_dw;
    logic signed [31:0]    n_d;
    logic signed [KSW-1:0] n_ksum;
    logic signed [31:0]    n_y;
    logic signed [31:0]    n_vn;
    logic [SUMW-1:0]       n_sum;
    logic signed [31:0]    n_ap;
    logic [CW+10:0]        w_cnt_ext;

    rk4dap_smul #(.AW(AW)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_mctl),
        .i_a     (r_ma),
        .i_b     (r_mb),
        .o_done  (w_mdone),
        .o_prod  (w_prod)
    );

    rk4dap_div6 #(.W(DVW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_dgo),
        .i_x     (r_dx),
        .o_done  (w_ddone),
        .o_q     (w_q)
    );

    // derivative: -g - v^2 * c, floor of the Q0.32 product, clamped below
    assign w_dw   = -G_W - signed'({2'b00, w_prod[PW-1:32]});
    assign n_d    = f_sat32(XW'(w_dw));
    assign n_ksum = r_ksum + (((r_stage == 2'd1) || (r_stage == 2'd2)) ?
                              (KSW'(n_d) <<< 1) : KSW'(n_d));
    // stage velocity: half step for k2, k3; full step for k4
    assign n_y    = f_sat32(XW'(r_v) + XW'((r_stage == 2'd2) ? (w_prod >>> 16)
                                                             : (w_prod >>> 17)));
    assign n_vn   = f_sat32(XW'(r_v) + XW'(w_q));
    assign n_sum  = r_sum + SUMW'(n_vn[31:0]);
    assign n_ap   = f_sat32(XW'(r_h) + XW'(w_prod >>> 16));
    assign w_cnt_ext = {11'd0, r_count};

    // sequencer and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cd         <= CD_RESET;
            r_step       <= STEP_RESET;
            r_mctl.start <= 1'b0;
            r_dgo        <= 1'b0;
            r_done       <= 1'b0;
        end else begin
            r_mctl.start <= 1'b0;
            r_dgo        <= 1'b0;
            r_done       <= 1'b0;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DRAG_COEFF: r_cd   <= i_cfg_data;
                    CFG_STEP_SIZE:  r_step <= i_cfg_data;
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_v          <= i_request.velocity;
                        r_h          <= i_request.height;
                        r_sum        <= '0;
                        r_count      <= '0;
                        r_ma         <= signed'(AW'(r_cd));
                        r_mb         <= MB_W'(i_request.brake_area);
                        r_mctl.len   <= LEN_Q16;
                        r_mctl.start <= 1'b1;
                        r_state      <= S_C1;
                    end
                end
                S_C1: begin
                    if (w_mdone) begin
                        r_ma         <= signed'(AW'(w_prod[31:0]));
                        r_mb         <= MB_W'(K_DRAG);
                        r_mctl.len   <= LEN_KDRG;
                        r_mctl.start <= 1'b1;
                        r_state      <= S_C2;
                    end
                end
                S_C2: begin
                    if (w_mdone) begin
                        r_c          <= w_prod[45:16];
                        r_stage      <= 2'd0;
                        r_ksum       <= '0;
                        r_ma         <= signed'(AW'(f_mag(r_v)));
                        r_mb         <= f_mag(r_v);
                        r_mctl.len   <= LEN_MAG;
                        r_mctl.start <= 1'b1;
                        r_state      <= S_SQ;
                    end
                end
                S_SQ: begin
                    if (w_mdone) begin
                        r_ma         <= signed'(AW'(w_prod[63:FRAC_BITS]));
                        r_mb         <= MB_W'(r_c);
                        r_mctl.len   <= LEN_C;
                        r_mctl.start <= 1'b1;
                        r_state      <= S_DR;
                    end
                end
                S_DR: begin
                    if (w_mdone) begin
                        r_ksum       <= n_ksum;
                        r_mb         <= MB_W'(r_step);
                        r_mctl.len   <= LEN_Q16;
                        r_mctl.start <= 1'b1;
                        if (r_stage == 2'd3) begin
                            r_ma    <= AW'(n_ksum);
                            r_state <= S_AC;
                        end else begin
                            r_ma    <= AW'(n_d);
                            r_state <= S_ST;
                        end
                    end
                end
                S_ST: begin
                    if (w_mdone) begin
                        r_stage      <= r_stage + 2'd1;
                        r_ma         <= signed'(AW'(f_mag(n_y)));
                        r_mb         <= f_mag(n_y);
                        r_mctl.len   <= LEN_MAG;
                        r_mctl.start <= 1'b1;
                        r_state      <= S_SQ;
                    end
                end
                S_AC: begin
                    if (w_mdone) begin
                        r_dx    <= DVW'(w_prod >>> 16);
                        r_dgo   <= 1'b1;
                        r_state <= S_DV;
                    end
                end
                S_DV: begin
                    if (w_ddone) begin
                        r_mb       <= MB_W'(r_step);
                        r_mctl.len <= LEN_Q16;
                        r_mctl.start <= 1'b1;
                        if (n_vn <= 32'sd0) begin
                            // apogee passed: close with the sum so far
                            r_limit <= 1'b0;
                            r_ma    <= signed'(AW'(r_sum));
                            r_state <= S_AP;
                        end else begin
                            r_v     <= n_vn;
                            r_sum   <= n_sum;
                            r_count <= r_count + CW'(1);
                            if (r_count == MAX_C - CW'(1)) begin
                                r_limit <= 1'b1;
                                r_ma    <= signed'(AW'(n_sum));
                                r_state <= S_AP;
                            end else begin
                                r_stage    <= 2'd0;
                                r_ksum     <= '0;
                                r_ma       <= signed'(AW'(f_mag(n_vn)));
                                r_mb       <= f_mag(n_vn);
                                r_mctl.len <= LEN_MAG;
                                r_state    <= S_SQ;
                            end
                        end
                    end
                end
                S_AP: begin
                    if (w_mdone) begin
                        r_res.apogee      <= n_ap;
                        r_res.steps_taken <= w_cnt_ext[10:0];
                        r_res.hit_limit   <= r_limit;
                        r_done            <= 1'b1;
                        r_state           <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

    // checks
    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    a_mul_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mdone |-> !((r_state == S_IDLE) || (r_state == S_DV)))
        else $error("multiplier finished outside a product state");

    a_units_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mdone && w_ddone))
        else $error("multiplier and divider finished together");

    a_limit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.hit_limit) |-> (r_count == MAX_C))
        else $error("limit flag without full step count");

endmodule

@@ test/rk4dap_checker.sv @@
// Checker for the RK4 drag apogee predictor: mirrors the two registers, forecasts
// each apogee from the accepted request and compares it with the block's result.
// Depends on rk4dap_pkg for the request and result payload types.
`timescale 1ns / 1ps

module rk4dap_checker #(
    parameter int MAX_STEPS = 1024,
    parameter int FRAC_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    input  logic                             busy,
    input  rk4dap_pkg::t_req                 i_request,
    input  logic                             o_done,
    input  rk4dap_pkg::t_res                 o_result,
    input  logic                             i_cfg_we,
    input  logic [rk4dap_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [15:0]                      i_cfg_data,
    output int                               o_errors,
    output int                               o_pending
);
    import rk4dap_pkg::*;

    localparam longint GRAV    = ((longint'(981) << FRAC_BITS) + 50) / 100;
    localparam longint KD_Q16  = ((longint'(1293) << 16) + 5000) / 10000;
    localparam longint S32_HI  = 64'sd2147483647;
    localparam longint S32_LO  = -64'sd2147483648;

    logic [15:0] cd_q;
    logic [15:0] step_q;
    t_res        pending_apogees[$];

    function automatic longint clamp32(longint x);
        if (x > S32_HI) return S32_HI;
        if (x < S32_LO) return S32_LO;
        return x;
    endfunction

    // dv/dt = -g - c * v^2, c in Q0.32
    function automatic longint accel(longint v, longint unsigned c);
        longint unsigned mag;
        longint unsigned sq;
        longint unsigned drag;
        mag  = (v < 0) ? longint'(-v) : longint'(v);
        sq   = (mag * mag) >> FRAC_BITS;
        drag = (sq >> 32) * c + (((sq & 64'hFFFF_FFFF) * c) >> 32);
        return clamp32(-GRAV - longint'(drag));
    endfunction

    function automatic longint rk4_advance(longint v, longint unsigned c, longint dt);
        longint a1, a2, a3, a4, acc, num, q;
        a1  = accel(v, c);
        a2  = accel(clamp32(v + ((dt * a1) >>> 17)), c);
        a3  = accel(clamp32(v + ((dt * a2) >>> 17)), c);
        a4  = accel(clamp32(v + ((dt * a3) >>> 16)), c);
        acc = a1 + 2 * a2 + 2 * a3 + a4;
        num = dt * acc;
        q   = num / (longint'(6) << 16);
        // round toward minus infinity
        if (num < 0 && q * (longint'(6) << 16) != num) q = q - 1;
        return clamp32(v + q);
    endfunction

    function automatic t_res apogee_forecast(t_req rq, logic [15:0] cd, logic [15:0] dt16);
        t_res          r;
        longint        v, ap, dt;
        longint unsigned c, sum;
        int            n;
        logic          capped;
        v      = longint'(rq.velocity);
        dt     = longint'(dt16);
        c      = (longint'(cd) * longint'(rq.brake_area) * KD_Q16) >> 16;
        sum    = 0;
        n      = 0;
        capped = 1'b1;
        for (int i = 0; i < MAX_STEPS; i++) begin
            v = rk4_advance(v, c, dt);
            if (v <= 0) begin
                capped = 1'b0;
                break;
            end
            sum += longint'(v);
            n++;
        end
        ap            = clamp32(longint'(rq.height) + longint'((sum * longint'(dt)) >> 16));
        r.apogee      = ap[31:0];
        r.steps_taken = n[10:0];
        r.hit_limit   = capped;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        o_errors++;
    endtask

    initial o_errors = 0;
    initial o_pending = 0;

    // register mirror, forecast on request, compare on result
    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            cd_q   <= CD_RESET;
            step_q <= STEP_RESET;
        end else begin
            if (o_done) begin
                if (pending_apogees.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    want = pending_apogees.pop_front();
                    if (o_result.apogee !== want.apogee)
                        report_mismatch("apogee", o_result.apogee, want.apogee);
                    if (o_result.steps_taken !== want.steps_taken)
                        report_mismatch("steps_taken", o_result.steps_taken, want.steps_taken);
                    if (o_result.hit_limit !== want.hit_limit)
                        report_mismatch("hit_limit", o_result.hit_limit, want.hit_limit);
                end
            end
            if (start && !busy)
                pending_apogees.push_back(apogee_forecast(i_request, cd_q, step_q));
            o_pending <= pending_apogees.size();
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_DRAG_COEFF) cd_q <= i_cfg_data;
                else if (i_cfg_idx == CFG_STEP_SIZE) step_q <= i_cfg_data;
            end
        end
    end
endmodule

@@ test/testbench.sv @@
// Top of the apogee predictor regression: clock, reset, request stimulus and verdict.
// Depends on rk4dap_pkg, rk4_drag_apogee_predictor_core and rk4dap_checker.
`timescale 1ns / 1ps

module testbench;
    import rk4dap_pkg::*;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    t_req                 i_request;
    logic                 o_done;
    t_res                 o_result;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [15:0]          i_cfg_data;
    int                   errors;
    int                   pending;
    int                   burst_left;

    rk4_drag_apogee_predictor_core dut (.*);

    rk4dap_checker chk (
        .i_clk, .i_rst_n, .start, .busy, .i_request, .o_done, .o_result,
        .i_cfg_we, .i_cfg_idx, .i_cfg_data, .o_errors(errors), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1; #4;
        i_clk = 1'b0; #4;
    end

    // send one request; gaps between bursts of random length
    task automatic send_request(logic signed [31:0] vel, logic signed [31:0] hgt,
                                logic [15:0] area);
        i_request = '{velocity: vel, height: hgt, brake_area: area};
        start     = 1'b1;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            start      = 1'b0;
            burst_left = $urandom_range(0, 4);
            repeat ($urandom_range(0, 6)) @(negedge i_clk);
        end
    endtask

    // registers only change with the block idle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        start = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    // mostly short flights so that runs stay brief
    task automatic random_request(int max_mps);
        logic signed [31:0] v;
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4) v = {1'b1, 31'($urandom)};
        else if (sel == 4) v = 32'sd0;
        else v = $urandom_range(0, max_mps << 16);
        send_request(v, $urandom, 16'($urandom));
    endtask

    initial begin
        start      = 1'b0;
        i_request  = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_DRAG_COEFF;
        i_cfg_data = '0;
        burst_left = 0;
        i_rst_n    = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n    = 1'b1;

        // reset values: tiny, zero and negative starts, saturating height
        send_request(32'sd1, 32'sd0, 16'd0);
        send_request(32'sd0, 32'sd100, 16'hFFFF);
        send_request(32'sh8000_0000, 32'sh8000_0000, 16'd0);
        send_request(32'sd10 <<< 16, 32'sh7FFF_FFFF, 16'd0);
        send_request(-(32'sd5 <<< 16), 32'sd0, 16'h8000);
        send_request(32'sd15 <<< 16, -(32'sd20 <<< 16), 16'hFFFF);

        // heaviest drag at the longest step: huge speeds collapse at once
        write_reg(CFG_DRAG_COEFF, 16'hFFFF);
        write_reg(CFG_STEP_SIZE, 16'hFFFF);
        send_request(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'hFFFF);
        send_request(32'sh7FFF_FFFF, 32'sh8000_0000, 16'hFFFF);
        send_request(32'sh4000_0000, 32'sd0, 16'h8000);
        send_request(32'sd30 <<< 16, 32'sd0, 16'd0);
        send_request(-(32'sd3000 <<< 16), 32'sd0, 16'hFFFF);

        // no drag, finest step, large register index must be ignored
        write_reg(CFG_DRAG_COEFF, 16'd0);
        write_reg(CFG_STEP_SIZE, 16'd1);
        write_reg(2'd3, 16'h1234);
        send_request(32'sh8000_0000, 32'sd7, 16'hFFFF);
        send_request(32'sd0, 32'sd7, 16'hFFFF);

        // zero step: a rising start runs to the iteration cap
        write_reg(CFG_STEP_SIZE, 16'd0);
        send_request(32'sd1 <<< 16, 32'sd1234, 16'h1111);
        send_request(-32'sd1, 32'sd1234, 16'h1111);

        // random requests across a few register settings
        write_reg(CFG_DRAG_COEFF, 16'd6554);
        write_reg(CFG_STEP_SIZE, 16'd6554);
        repeat (25) random_request(20);
        write_reg(CFG_DRAG_COEFF, 16'hFFFF);
        write_reg(CFG_STEP_SIZE, 16'hFFFF);
        repeat (25) random_request(80);
        write_reg(CFG_DRAG_COEFF, 16'd0);
        write_reg(CFG_STEP_SIZE, 16'd13107);
        repeat (25) random_request(20);
        write_reg(CFG_DRAG_COEFF, 16'd40000);
        write_reg(CFG_STEP_SIZE, 16'd32768);
        repeat (25) random_request(40);

        start = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // run limit
    initial begin
        #1_500_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule

@@ sim.f @@
hw/rtl/rk4dap_pkg.sv
hw/rtl/rk4dap_smul.sv
hw/rtl/rk4dap_div6.sv
hw/rtl/rk4_drag_apogee_predictor_core.sv
test/rk4dap_checker.sv
test/testbench.sv
